// File: hdl/nlep_pkg.sv
`default_nettype none

package nlep_pkg;

   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 32;
   localparam int CHAR_BITS  = 8;
   localparam int OUT_BITS   = 32;

   // Division by ten as a reciprocal multiply, exact for every VALUE_BITS-wide value
   localparam int                  DIV10_SHIFT = VALUE_BITS + 3;
   localparam logic [VALUE_BITS-1:0] DIV10_MUL  =
      VALUE_BITS'(((128'd1 << DIV10_SHIFT) + 128'd9) / 128'd10);
   localparam int                  HEX_SHIFT   = 4;

   localparam logic [CHAR_BITS-1:0] KEY_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] KEY_BS    = 8'h08;
   localparam logic [CHAR_BITS-1:0] CHAR_0    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_9    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UA   = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UF   = 8'h46;
   localparam logic [CHAR_BITS-1:0] CHAR_LA   = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LF   = 8'h66;
   localparam logic [3:0]           DIGIT_TEN = 4'hA;

   typedef enum logic {
      KIND_ECHO   = 1'b0,
      KIND_NUMBER = 1'b1
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type digit_of(input logic [CHAR_BITS-1:0] c, input logic hex);
      digit_type d;
      d.valid = 1'b0;
      d.value = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d.valid = 1'b1;
         d.value = 4'(c - CHAR_0);
      end else if (hex && c >= CHAR_UA && c <= CHAR_UF) begin
         d.valid = 1'b1;
         d.value = 4'(c - CHAR_UA) + DIGIT_TEN;
      end else if (hex && c >= CHAR_LA && c <= CHAR_LF) begin
         d.valid = 1'b1;
         d.value = 4'(c - CHAR_LA) + DIGIT_TEN;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// File: hdl/nlep_req_if.sv
`default_nettype none

interface nlep_req_if
   import nlep_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// File: hdl/nlep_rsp_if.sv
`default_nettype none

interface nlep_rsp_if
   import nlep_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [CHAR_BITS-1:0] echo_char;
   logic [OUT_BITS-1:0]  number_out;

   modport source (output valid, output kind, output echo_char, output number_out,
                   input ready);
   modport sink   (input valid, input kind, input echo_char, input number_out,
                   output ready);
endinterface

`default_nettype wire

// File: hdl/numeric_line_entry_parser.sv
`default_nettype none

// Channel    Direction  Handshake      Payload
// req_chan   in         valid/ready    char_in[7:0]
// rsp_chan   out        valid/ready    kind, echo_char[7:0], number_out[31:0]
// csr        in         csr_wr_en      csr_wr_data (radix_hex)
//
// A character is registered in the hold register on acceptance and decoded from there;
// the value update and any echo or finished number are written to the result register.
// Sustained rate is one character per cycle while the result register is not stalled.
// The path through the value register holds the reciprocal multiply used for backspace
// in decimal mode. Synchronous reset clears the value, digit count, radix and valid flags.
// A stalled result register holds both stages, also for characters that give no result.

module numeric_line_entry_parser
   import nlep_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   nlep_req_if.sink    req_chan,
   nlep_rsp_if.source  rsp_chan,
   input  wire         csr_wr_en,
   input  wire         csr_wr_data
);

   logic                  radix_hex_ff;
   logic                  hold_valid_ff, hold_valid_in;
   logic [CHAR_BITS-1:0]  hold_char_ff, hold_char_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [CHAR_BITS-1:0]  rsp_echo_ff, rsp_echo_in;
   logic [OUT_BITS-1:0]   rsp_number_ff, rsp_number_in;

   logic                      advance;
   logic                      process;
   digit_type                 digit;
   logic [2*VALUE_BITS-1:0]   div_prod;
   logic [VALUE_BITS-1:0]     value_div;
   logic [VALUE_BITS-1:0]     value_mul;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !hold_valid_ff || advance;
   assign process        = hold_valid_ff && advance;
   assign digit          = digit_of(hold_char_ff, radix_hex_ff);

   assign div_prod  = (2*VALUE_BITS)'(value_ff) * (2*VALUE_BITS)'(DIV10_MUL);
   assign value_div = radix_hex_ff ? (value_ff >> HEX_SHIFT)
                                   : VALUE_BITS'(div_prod >> DIV10_SHIFT);
   assign value_mul = radix_hex_ff ? (value_ff << HEX_SHIFT)
                                   : (value_ff << 3) + (value_ff << 1);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_char_in  = hold_char_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_echo_in   = rsp_echo_ff;
      rsp_number_in = rsp_number_ff;

      if (req_chan.ready) begin
         hold_valid_in = req_chan.valid;
         hold_char_in  = req_chan.char_in;
      end

      if (advance) begin
         rsp_valid_in = 1'b0;
      end

      if (process) begin
         if (hold_char_ff == KEY_CR) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_NUMBER;
            rsp_echo_in   = '0;
            rsp_number_in = OUT_BITS'(value_ff);
            value_in      = '0;
            count_in      = '0;
         end else if (digit.valid) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_ECHO;
            rsp_echo_in   = hold_char_ff;
            rsp_number_in = '0;
            value_in      = value_mul + VALUE_BITS'(digit.value);
            count_in      = count_ff + 1'b1;
         end else if (hold_char_ff == KEY_BS && count_ff != '0) begin
            // drop the last digit
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_ECHO;
            rsp_echo_in   = hold_char_ff;
            rsp_number_in = '0;
            value_in      = value_div;
            count_in      = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_hex_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         value_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            radix_hex_ff <= csr_wr_data;
         end
         hold_valid_ff <= hold_valid_in;
         value_ff      <= value_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_char_ff  <= hold_char_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_echo_ff   <= rsp_echo_in;
      rsp_number_ff <= rsp_number_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.echo_char  = rsp_echo_ff;
   assign rsp_chan.number_out = rsp_number_ff;

   a_cr_clears: assert property (@(posedge clock) disable iff (reset)
      process && hold_char_ff == KEY_CR |=> value_ff == '0 && count_ff == '0)
      else $error("value or digit count not cleared after carriage return");

   a_bs_empty_silent: assert property (@(posedge clock) disable iff (reset)
      process && hold_char_ff == KEY_BS && count_ff == '0 |=> !rsp_valid_ff)
      else $error("backspace with no digits produced a transaction");

   a_number_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_NUMBER |-> rsp_echo_ff == '0)
      else $error("finished number carries an echo character");

   a_echo_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_ECHO |-> rsp_number_ff == '0)
      else $error("echo transaction carries a number");

endmodule

`default_nettype wire

// File: verif/numeric_line_entry_parser_checker.sv
`timescale 1ns / 100ps

module numeric_line_entry_parser_checker
   import nlep_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_ready,
   input  wire [CHAR_BITS-1:0] req_char_in,
   input  wire                 rsp_valid,
   input  wire                 rsp_ready,
   input  wire                 rsp_kind,
   input  wire [CHAR_BITS-1:0] rsp_echo_char,
   input  wire [OUT_BITS-1:0]  rsp_number_out,
   input  wire                 csr_wr_en,
   input  wire                 csr_wr_data,
   output int                  mismatch_count,
   output int                  pending_count
);

   localparam int         REPORT_LIMIT = 10;
   localparam logic [4:0] NO_DIGIT     = 5'h10;

   typedef struct packed {
      kind_type             kind;
      logic [CHAR_BITS-1:0] echo_char;
      logic [OUT_BITS-1:0]  number_out;
   } entry_result_type;

   logic [VALUE_BITS-1:0] entry_value;
   logic [COUNT_BITS-1:0] entry_digits;
   logic                  radix_hex;
   entry_result_type      expected_results[$];

   function automatic logic [4:0] char_digit(input logic [CHAR_BITS-1:0] c, input logic hex);
      if (c >= CHAR_0 && c <= CHAR_9) begin
         return 5'(c - CHAR_0);
      end
      if (hex && c >= CHAR_UA && c <= CHAR_UF) begin
         return 5'(c - CHAR_UA) + 5'(DIGIT_TEN);
      end
      if (hex && c >= CHAR_LA && c <= CHAR_LF) begin
         return 5'(c - CHAR_LA) + 5'(DIGIT_TEN);
      end
      return NO_DIGIT;
   endfunction

   // Update the entry state for one character and queue the echo or number it yields.
   task automatic advance_entry(input logic [CHAR_BITS-1:0] c);
      logic [4:0]            digit;
      logic [VALUE_BITS-1:0] base;
      entry_result_type      res;
      base           = radix_hex ? VALUE_BITS'(16) : VALUE_BITS'(10);
      digit          = char_digit(c, radix_hex);
      res.kind       = KIND_ECHO;
      res.echo_char  = c;
      res.number_out = '0;
      if (c == KEY_CR) begin
         res.kind       = KIND_NUMBER;
         res.echo_char  = '0;
         res.number_out = OUT_BITS'(entry_value);
         entry_value    = '0;
         entry_digits   = '0;
         expected_results.push_back(res);
      end else if (digit != NO_DIGIT) begin
         entry_value  = entry_value * base + VALUE_BITS'(digit);
         entry_digits = entry_digits + 1'b1;
         expected_results.push_back(res);
      end else if (c == KEY_BS && entry_digits != 0) begin
         entry_value  = entry_value / base;
         entry_digits = entry_digits - 1'b1;
         expected_results.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      entry_result_type got;
      entry_result_type want;
      if (reset) begin
         entry_value    = '0;
         entry_digits   = '0;
         radix_hex      = 1'b0;
         mismatch_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind       = kind_type'(rsp_kind);
            got.echo_char  = rsp_echo_char;
            got.number_out = rsp_number_out;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: result kind=%0d echo=%02h number=%08h with nothing pending",
                           $realtime, got.kind, got.echo_char, got.number_out);
               end
            end else begin
               want = expected_results.pop_front();
               if (got.kind != want.kind || got.echo_char != want.echo_char ||
                   got.number_out != want.number_out) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch expected kind=%0d echo=%02h number=%08h",
                              $realtime, want.kind, want.echo_char, want.number_out);
                     $display("%0t:          actual   kind=%0d echo=%02h number=%08h",
                              $realtime, got.kind, got.echo_char, got.number_out);
                  end
               end
            end
         end
         if (csr_wr_en) begin
            radix_hex = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            advance_entry(req_char_in);
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// File: verif/numeric_line_entry_parser_test.sv
`timescale 1ns / 100ps

module numeric_line_entry_parser_test
   import nlep_pkg::*;
();

   localparam int RESET_CYCLES     = 12;
   localparam int PHASES           = 10;
   localparam int PHASE_ITEMS      = 195;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int SETTLE_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT   = 2000;

   logic clock       = 1'b0;
   logic reset       = 1'b1;
   logic csr_wr_en   = 1'b0;
   logic csr_wr_data = 1'b0;
   bit   idling_on   = 1'b1;
   int   long_holds_requested = 0;
   int   long_holds_done      = 0;
   int   hold_left    = 0;
   int   stall_left   = 0;
   int   phase_items  = 0;
   int   quiet_cycles = 0;
   int   mismatch_count;
   int   pending_count;

   nlep_req_if req_chan();
   nlep_rsp_if rsp_chan();

   numeric_line_entry_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   numeric_line_entry_parser_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_char_in    (req_chan.char_in),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_kind       (rsp_chan.kind),
      .rsp_echo_char  (rsp_chan.echo_char),
      .rsp_number_out (rsp_chan.number_out),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: a long hold when asked for, otherwise random stall bursts.
   always @(negedge clock) begin
      if (long_holds_requested != long_holds_done) begin
         long_holds_done++;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** numeric_line_entry_parser: FAILED **");
         $finish;
      end
   end

   // Offer one character, with an occasional random gap first, and hold it until the transaction.
   task automatic send_char(input logic [CHAR_BITS-1:0] c);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.char_in <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      phase_items++;
   endtask

   function automatic logic [CHAR_BITS-1:0] random_digit(input logic hex);
      int pick;
      pick = hex ? $urandom_range(0, 21) : $urandom_range(0, 9);
      if (pick < 10) begin
         return CHAR_0 + CHAR_BITS'(pick);
      end
      if (pick < 16) begin
         return CHAR_UA + CHAR_BITS'(pick - 10);
      end
      return CHAR_LA + CHAR_BITS'(pick - 16);
   endfunction

   // One typed number: digits with stray backspaces and noise, mostly closed by a return.
   task automatic send_entry(input logic hex);
      int len;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
         send_char(random_digit(hex));
         if ($urandom_range(0, 9) == 0) begin
            send_char(KEY_BS);
         end
         if ($urandom_range(0, 24) == 0) begin
            send_char($urandom_range(0, 1) ? CHAR_BITS'($urandom_range(0, 255))
                                           : random_digit(!hex));
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) send_char(KEY_BS);
      end
      if ($urandom_range(0, 11) != 0) begin
         send_char(KEY_CR);
      end
   endtask

   // Drop valid and let every pending result and any trailing character drain.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_radix(input logic hex);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= hex;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [CHAR_BITS-1:0] dec_chars[13];
      logic [CHAR_BITS-1:0] hex_chars[11];
      logic                 hex;
      req_chan.valid   = 1'b0;
      req_chan.char_in = '0;
      rsp_chan.ready   = 1'b0;
      dec_chars = '{KEY_CR, KEY_BS, 8'h00, 8'hFF, 8'h2F, 8'h3A, CHAR_UA,
                    CHAR_0, CHAR_9, KEY_BS, KEY_BS, KEY_BS, KEY_CR};
      hex_chars = '{CHAR_UF, CHAR_LF, CHAR_UF, CHAR_LF, CHAR_UF, CHAR_LF, CHAR_UF, CHAR_UF,
                    8'h47, 8'h60, KEY_CR};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Decimal out of reset: empty entry, lone backspace, range edges around the digits.
      foreach (dec_chars[i]) send_char(dec_chars[i]);
      wait_for_results();
      write_radix(1'b1);
      foreach (hex_chars[i]) send_char(hex_chars[i]);

      for (int p = 0; p < PHASES; p++) begin
         wait_for_results();
         hex = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
         write_radix(hex);
         if (p == PHASES - 1) begin
            idling_on = 1'b0;
         end
         if (p == 2) begin
            @(posedge clock);
            long_holds_requested++;
            @(negedge clock);
         end
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               send_char(CHAR_BITS'($urandom_range(0, 255)));
            end else begin
               send_entry(hex);
            end
         end
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("** numeric_line_entry_parser: PASSED **");
      end else begin
         $display("** numeric_line_entry_parser: FAILED **");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/nlep_pkg.sv
hdl/nlep_req_if.sv
hdl/nlep_rsp_if.sv
hdl/numeric_line_entry_parser.sv
verif/numeric_line_entry_parser_checker.sv
verif/numeric_line_entry_parser_test.sv
